>>> sv/infix_to_postfix_converter_unit_macros.svh
// assertion macros for the infix to postfix converter
// used by the top level; expects clk and rst_n in scope
`ifndef INFIX_TO_POSTFIX_CONVERTER_UNIT_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_UNIT_MACROS_SVH

// implication checked at every edge outside reset
`define ITP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition that must hold at every edge outside reset
`define ITP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

>>> sv/itp_pkg.sv
// shared types, character codes and helper functions for the converter
// no dependencies
package itp_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 32;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_POW   = 8'h5E;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_TERM  = 8'h00;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMIT,
    ST_READ,
    ST_CHECK,
    ST_PUSH
  } state_t;

  typedef enum logic [1:0] {
    MODE_OP,
    MODE_CLOSE,
    MODE_END
  } mode_t;

  function automatic logic [1:0] prec_of(input logic [7:0] c);
    logic [1:0] p;
    p = 2'd0;
    if (c == CH_PLUS || c == CH_MINUS) p = 2'd1;
    else if (c == CH_MUL || c == CH_DIV) p = 2'd2;
    else if (c == CH_POW) p = 2'd3;
    return p;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UZ) ||
           (c >= CH_LA && c <= CH_LZ);
  endfunction

  function automatic logic is_operator(input logic [7:0] c);
    return c == CH_PLUS || c == CH_MINUS || c == CH_MUL || c == CH_DIV ||
           c == CH_POW;
  endfunction

endpackage

>>> sv/itp_if.sv
// valid/ready channel interfaces for the converter input and result streams
// no dependencies
interface itp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       end_of_expr;

  modport source (output valid, output symbol, output end_of_expr, input ready);
  modport sink   (input valid, input symbol, input end_of_expr, output ready);
endinterface

interface itp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_symbol;
  logic       last_of_run;
  logic       overflow;

  modport source (output valid, output out_symbol, output last_of_run,
                  output overflow, input ready);
  modport sink   (input valid, input out_symbol, input last_of_run,
                  input overflow, output ready);
endinterface

>>> sv/itp_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module itp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> sv/infix_to_postfix_converter_unit.sv
// infix to postfix converter (shunting-yard) top level
// depends on itp_pkg, itp_if, itp_ram and infix_to_postfix_converter_unit_macros.svh
//
// usage:
//   in_ch takes one character per transfer, or an end marker (end_of_expr set)
//   out_ch gives postfix characters; last_of_run marks the last result of an
//   input item, and the end marker's final result is a zero terminator whose
//   overflow bit reports any push dropped on a full stack since the last one
// timing:
//   in_ch.ready is high only while the sequencer is idle; one item at a time
//   an operand passes the emit state into the output register; an open
//   parenthesis passes the push state; an ignored character leaves it idle
//   each popped stack entry takes a read state (stack ram read of the new
//   top) and then a check state (compare and emit); an operator or closing
//   parenthesis takes a check and then the pops, and an operator the push;
//   the end marker emits its last pop in a further check before the terminator
// reset: stack empty, overflow flag clear, no result pending
// stall: a result waits in the output register; the sequencer holds while it
//   needs that register and it is still full
module infix_to_postfix_converter_unit #(
  parameter int unsigned STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  itp_in_if.sink            in_ch,
  itp_out_if.source         out_ch
);

  `include "infix_to_postfix_converter_unit_macros.svh"

  localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);

  itp_pkg::state_t state_r, state_nxt;
  itp_pkg::mode_t  mode_r, mode_nxt;
  logic [7:0]       sym_r, sym_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_seen_r, ovf_seen_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  logic [7:0]       pend_sym_r, pend_sym_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_sym_r, out_sym_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_ovf_r, out_ovf_nxt;

  logic              slot_free;
  logic              wr_en;
  logic [CNT_W-1:0]  top_idx;
  logic [7:0]        top_sym;
  logic              pop_ok;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign top_idx   = count_r - CNT_W'(1);

  itp_ram #(
    .WIDTH (8),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[ADDR_W-1:0]),
    .wr_data (sym_r),
    .rd_addr (top_idx[ADDR_W-1:0]),
    .rd_data (top_sym)
  );

  assign in_ch.ready       = (state_r == itp_pkg::ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_symbol = out_sym_r;
  assign out_ch.last_of_run = out_last_r;
  assign out_ch.overflow   = out_ovf_r;

  always_comb begin
    pop_ok = 1'b0;
    if (count_r != '0) begin
      unique case (mode_r)
        itp_pkg::MODE_END:   pop_ok = 1'b1;
        itp_pkg::MODE_CLOSE: pop_ok = (top_sym != itp_pkg::CH_OPEN);
        itp_pkg::MODE_OP:
          pop_ok = (itp_pkg::prec_of(top_sym) >= itp_pkg::prec_of(sym_r));
        default:             pop_ok = 1'b0;
      endcase
    end
  end

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    sym_nxt        = sym_r;
    count_nxt      = count_r;
    ovf_seen_nxt   = ovf_seen_r;
    pend_valid_nxt = pend_valid_r;
    pend_sym_nxt   = pend_sym_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_sym_nxt    = out_sym_r;
    out_last_nxt   = out_last_r;
    out_ovf_nxt    = out_ovf_r;
    wr_en          = 1'b0;

    unique case (state_r)
      itp_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          sym_nxt = in_ch.symbol;
          priority if (in_ch.end_of_expr) begin
            mode_nxt  = itp_pkg::MODE_END;
            state_nxt = itp_pkg::ST_CHECK;
          end else if (itp_pkg::is_alnum(in_ch.symbol)) begin
            state_nxt = itp_pkg::ST_EMIT;
          end else if (in_ch.symbol == itp_pkg::CH_OPEN) begin
            state_nxt = itp_pkg::ST_PUSH;
          end else if (in_ch.symbol == itp_pkg::CH_CLOSE) begin
            mode_nxt  = itp_pkg::MODE_CLOSE;
            state_nxt = itp_pkg::ST_CHECK;
          end else if (itp_pkg::is_operator(in_ch.symbol)) begin
            mode_nxt  = itp_pkg::MODE_OP;
            state_nxt = itp_pkg::ST_CHECK;
          end else begin
            state_nxt = itp_pkg::ST_IDLE;
          end
        end
      end

      itp_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_sym_nxt   = sym_r;
          out_last_nxt  = 1'b1;
          out_ovf_nxt   = 1'b0;
          state_nxt     = itp_pkg::ST_IDLE;
        end
      end

      itp_pkg::ST_READ: begin
        state_nxt = itp_pkg::ST_CHECK;
      end

      itp_pkg::ST_CHECK: begin
        priority if (pop_ok) begin
          if (!pend_valid_r || slot_free) begin
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_sym_nxt   = pend_sym_r;
              out_last_nxt  = 1'b0;
              out_ovf_nxt   = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_sym_nxt   = top_sym;
            count_nxt      = count_r - CNT_W'(1);
            state_nxt      = itp_pkg::ST_READ;
          end
        end else if (mode_r == itp_pkg::MODE_END) begin
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            if (pend_valid_r) begin
              out_sym_nxt    = pend_sym_r;
              out_last_nxt   = 1'b0;
              out_ovf_nxt    = 1'b0;
              pend_valid_nxt = 1'b0;
            end else begin
              out_sym_nxt  = itp_pkg::CH_TERM;
              out_last_nxt = 1'b1;
              out_ovf_nxt  = ovf_seen_r;
              ovf_seen_nxt = 1'b0;
              state_nxt    = itp_pkg::ST_IDLE;
            end
          end
        end else begin
          if (!pend_valid_r || slot_free) begin
            if (pend_valid_r) begin
              out_valid_nxt  = 1'b1;
              out_sym_nxt    = pend_sym_r;
              out_last_nxt   = 1'b1;
              out_ovf_nxt    = 1'b0;
              pend_valid_nxt = 1'b0;
            end
            if (mode_r == itp_pkg::MODE_OP) begin
              state_nxt = itp_pkg::ST_PUSH;
            end else begin
              // drop the matching open parenthesis if one is on top
              if (count_r != '0) count_nxt = count_r - CNT_W'(1);
              state_nxt = itp_pkg::ST_IDLE;
            end
          end
        end
      end

      itp_pkg::ST_PUSH: begin
        if (count_r == CNT_W'(STACK_DEPTH)) begin
          ovf_seen_nxt = 1'b1;
        end else begin
          wr_en     = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
        state_nxt = itp_pkg::ST_IDLE;
      end

      default: state_nxt = itp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= itp_pkg::ST_IDLE;
      count_r      <= '0;
      ovf_seen_r   <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      ovf_seen_r   <= ovf_seen_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    sym_r      <= sym_nxt;
    pend_sym_r <= pend_sym_nxt;
    out_sym_r  <= out_sym_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  `ITP_ASSERT_IMPL(a_idle_no_pending, state_r == itp_pkg::ST_IDLE, !pend_valid_r, "pending pop left when idle")
  `ITP_ASSERT_ALWAYS(a_count_in_range, count_r <= CNT_W'(STACK_DEPTH), "stack count beyond depth")
  `ITP_ASSERT_IMPL(a_term_is_last, out_valid_r && out_sym_r == itp_pkg::CH_TERM, out_last_r, "terminator without last flag")
  `ITP_ASSERT_IMPL(a_ovf_only_term, out_valid_r && out_ovf_r, out_sym_r == itp_pkg::CH_TERM, "overflow flag on a non-terminator")

endmodule

>>> dv/itp_checker.sv
`timescale 1ns / 100ps
// checker for the infix to postfix converter: watches both channels, predicts the
// postfix stream from every input transfer and compares each result transfer
// depends on itp_pkg and the itp_in_if / itp_out_if interfaces
module itp_checker #(
  parameter int unsigned DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  itp_in_if           in_ch,
  itp_out_if          out_ch,
  output int unsigned mismatches,
  output int unsigned pending,
  output int unsigned compared,
  output int unsigned terminators,
  output int unsigned overflow_terms
);

  typedef struct packed {
    logic [7:0] out_symbol;
    logic       last_of_run;
    logic       overflow;
  } postfix_char_t;

  postfix_char_t expected_postfix[$];
  logic [7:0]    op_stack [0:63];
  int unsigned   stack_fill;
  logic          overflow_seen;

  function automatic logic [1:0] op_rank(input logic [7:0] c);
    case (c)
      itp_pkg::CH_PLUS, itp_pkg::CH_MINUS: return 2'd1;
      itp_pkg::CH_MUL, itp_pkg::CH_DIV:    return 2'd2;
      itp_pkg::CH_POW:                     return 2'd3;
      default:                             return 2'd0;
    endcase
  endfunction

  function automatic bit is_operand_char(input logic [7:0] c);
    return (c >= itp_pkg::CH_0 && c <= itp_pkg::CH_9) ||
           (c >= itp_pkg::CH_UA && c <= itp_pkg::CH_UZ) ||
           (c >= itp_pkg::CH_LA && c <= itp_pkg::CH_LZ);
  endfunction

  function automatic void queue_char(input logic [7:0] c, input logic ovf);
    postfix_char_t r;
    r.out_symbol  = c;
    r.last_of_run = 1'b0;
    r.overflow    = ovf;
    expected_postfix.push_back(r);
  endfunction

  function automatic void pop_to_output();
    queue_char(op_stack[stack_fill - 1], 1'b0);
    stack_fill--;
  endfunction

  function automatic void push_op(input logic [7:0] c);
    if (stack_fill >= DEPTH || stack_fill >= 64) begin
      overflow_seen = 1'b1;
    end else begin
      op_stack[stack_fill] = c;
      stack_fill++;
    end
  endfunction

  function automatic void convert_symbol(input logic [7:0] c, input logic eoe);
    int unsigned   before_cnt;
    postfix_char_t tail;
    before_cnt = expected_postfix.size();
    if (eoe) begin
      while (stack_fill > 0) pop_to_output();
      queue_char(itp_pkg::CH_TERM, overflow_seen);
      overflow_seen = 1'b0;
    end else if (is_operand_char(c)) begin
      queue_char(c, 1'b0);
    end else if (c == itp_pkg::CH_OPEN) begin
      push_op(c);
    end else if (c == itp_pkg::CH_CLOSE) begin
      while (stack_fill > 0 && op_stack[stack_fill - 1] != itp_pkg::CH_OPEN) begin
        pop_to_output();
      end
      if (stack_fill > 0) stack_fill--;
    end else if (op_rank(c) != 2'd0) begin
      while (stack_fill > 0 && op_rank(op_stack[stack_fill - 1]) >= op_rank(c)) begin
        pop_to_output();
      end
      push_op(c);
    end
    // mark the final result of this item
    if (expected_postfix.size() > before_cnt) begin
      tail = expected_postfix.pop_back();
      tail.last_of_run = 1'b1;
      expected_postfix.push_back(tail);
    end
  endfunction

  always @(posedge clk) begin
    postfix_char_t want;
    if (!rst_n) begin
      stack_fill     = 0;
      overflow_seen  = 1'b0;
      expected_postfix.delete();
      mismatches     = 0;
      compared       = 0;
      terminators    = 0;
      overflow_terms = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_postfix.size() == 0) begin
          $error("out_symbol: expected nothing, actual %02h", out_ch.out_symbol);
          mismatches++;
        end else begin
          want = expected_postfix.pop_front();
          compared++;
          if (want.out_symbol == itp_pkg::CH_TERM) terminators++;
          if (want.out_symbol == itp_pkg::CH_TERM && want.overflow) overflow_terms++;
          if (out_ch.out_symbol !== want.out_symbol) begin
            $error("out_symbol: expected %02h, actual %02h", want.out_symbol,
                   out_ch.out_symbol);
            mismatches++;
          end
          if (out_ch.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, actual %0b", want.last_of_run,
                   out_ch.last_of_run);
            mismatches++;
          end
          if (out_ch.overflow !== want.overflow) begin
            $error("overflow: expected %0b, actual %0b", want.overflow, out_ch.overflow);
            mismatches++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) convert_symbol(in_ch.symbol, in_ch.end_of_expr);
    end
    pending = expected_postfix.size();
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// testbench top for the infix to postfix converter: clock, reset, stimulus,
// receiver stalls, watchdog and verdict; depends on itp_pkg, itp_if, itp_checker and the converter
module tb;

  localparam int unsigned DEPTH        = itp_pkg::STACK_DEPTH_DEF;
  localparam int unsigned RANDOM_ITEMS = 420;
  localparam int unsigned CALM_TAIL    = 60;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned QUIET_LIMIT  = 3000;
  localparam int unsigned DRAIN_CYCLES = 20;

  logic clk;
  logic rst_n;

  itp_in_if  in_ch ();
  itp_out_if out_ch ();

  int unsigned mismatches;
  int unsigned pending;
  int unsigned compared;
  int unsigned terminators;
  int unsigned overflow_terms;
  int unsigned items_sent;
  int unsigned quiet_cycles;
  bit          send_gaps;
  bit          recv_gaps;
  bit          hold_req;
  logic [7:0]  infix_text[$];

  infix_to_postfix_converter_unit #(
    .STACK_DEPTH(DEPTH)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  itp_checker #(
    .DEPTH(DEPTH)
  ) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .mismatches    (mismatches),
    .pending       (pending),
    .compared      (compared),
    .terminators   (terminators),
    .overflow_terms(overflow_terms)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] pick_operand();
    int unsigned r;
    r = $urandom_range(0, 61);
    if (r < 10) return itp_pkg::CH_0 + 8'(r);
    else if (r < 36) return itp_pkg::CH_UA + 8'(r - 10);
    else return itp_pkg::CH_LA + 8'(r - 36);
  endfunction

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(0, 4))
      0:       return itp_pkg::CH_PLUS;
      1:       return itp_pkg::CH_MINUS;
      2:       return itp_pkg::CH_MUL;
      3:       return itp_pkg::CH_DIV;
      default: return itp_pkg::CH_POW;
    endcase
  endfunction

  // well-formed expression with random nesting
  function automatic void build_expression();
    int unsigned n_operands;
    int unsigned open_cnt;
    n_operands = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 5);
    open_cnt = 0;
    for (int unsigned i = 0; i < n_operands; i++) begin
      while ($urandom_range(0, 3) == 0 && open_cnt < 6) begin
        infix_text.push_back(itp_pkg::CH_OPEN);
        open_cnt++;
      end
      infix_text.push_back(pick_operand());
      while (open_cnt > 0 && $urandom_range(0, 2) == 0) begin
        infix_text.push_back(itp_pkg::CH_CLOSE);
        open_cnt--;
      end
      if (i + 1 < n_operands) infix_text.push_back(pick_operator());
    end
    while (open_cnt > 0) begin
      infix_text.push_back(itp_pkg::CH_CLOSE);
      open_cnt--;
    end
  endfunction

  // every symbol pushes, so the stack runs past full
  function automatic void build_deep_nest();
    int unsigned n;
    n = $urandom_range(DEPTH + 1, DEPTH + 8);
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 2 == 0 || $urandom_range(0, 2) == 0) infix_text.push_back(itp_pkg::CH_OPEN);
      else infix_text.push_back(pick_operator());
    end
    infix_text.push_back(pick_operand());
  endfunction

  // broken sequences and arbitrary bytes
  function automatic void build_noise();
    int unsigned n;
    n = $urandom_range(1, 8);
    for (int unsigned i = 0; i < n; i++) begin
      case ($urandom_range(0, 4))
        0:       infix_text.push_back(8'($urandom_range(0, 255)));
        1:       infix_text.push_back(itp_pkg::CH_OPEN);
        2:       infix_text.push_back(itp_pkg::CH_CLOSE);
        3:       infix_text.push_back(pick_operator());
        default: infix_text.push_back(pick_operand());
      endcase
    end
  endfunction

  task automatic send_item(input logic [7:0] sym, input logic eoe);
    int unsigned gap;
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_ch.valid  <= 1'b0;
      in_ch.symbol <= 8'($urandom_range(0, 255));
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.symbol      <= sym;
    in_ch.end_of_expr <= eoe;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic send_buffer();
    foreach (infix_text[i]) send_item(infix_text[i], 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // receiver
  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned start_cnt;
    int unsigned expr_idx;
    int unsigned kind;
    bit          calm;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.symbol      <= 8'h00;
    in_ch.end_of_expr <= 1'b0;
    items_sent   = 0;
    quiet_cycles = 0;
    send_gaps    = 1'b1;
    recv_gaps    = 1'b1;
    hold_req     = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // alnum bounds, every operator but plus, left-assoc power, ignored bytes
    send_text("(0-9)^A^z*Z/a");
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
    // unmatched closing parens
    send_text("+))");
    send_item(8'h00, 1'b1);
    // stray opening parens flushed at end
    send_text("((");
    send_item(8'h80, 1'b1);

    // receiver holds off while the sender keeps offering
    hold_req  = 1'b1;
    start_cnt = items_sent;
    expr_idx  = 0;
    while (items_sent - start_cnt < RANDOM_ITEMS) begin
      if (items_sent - start_cnt >= RANDOM_ITEMS - CALM_TAIL) begin
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
      end else begin
        calm      = ($urandom_range(0, 4) == 0);
        send_gaps = !calm;
        recv_gaps = !calm;
      end
      infix_text.delete();
      kind = $urandom_range(0, 11);
      if (expr_idx == 1 || kind == 0) build_deep_nest();
      else if (kind <= 2) build_noise();
      else build_expression();
      send_buffer();
      expr_idx++;
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d input transfers, %0d expressions, %0d results compared",
             items_sent, terminators, compared);
    $display("summary: %0d terminators flagged a full-stack drop", overflow_terms);
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/itp_pkg.sv
sv/itp_if.sv
sv/itp_ram.sv
sv/infix_to_postfix_converter_unit.sv
dv/itp_checker.sv
dv/tb.sv
